@@ hdl/assert_macros.svh @@
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off during reset
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, off during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// implication into the next cycle, checked during reset too
`define ASSERT_NEXT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bbt_pkg.sv @@
// package: constants, widths and knot table of the temperature to rgb pipeline
`default_nettype none
package bbt_pkg;
    localparam int OUT_FRAC_BITS = 12;
    localparam int TW = 16;
    localparam int OW = 16;
    localparam int T_MIN = 1000;
    localparam int T_MAX = 10000;
    localparam int SEG_K = 500;
    localparam int SEG_SQ = 250000;
    localparam int SEG_CU = 125000000;
    localparam int SEG_RECIP = 8389;
    localparam int SEG_SHIFT = 22;
    localparam int LUM_SCALE = 10000;
    localparam int W_R = 2126;
    localparam int W_G = 7152;
    localparam int W_B = 722;
    localparam int QBITS = 18;
    localparam int DW = 14;
    localparam int IW = 5;
    localparam int RW = 9;
    localparam int KW = 17;
    localparam int CW = 23;
    localparam int AW = 32;
    localparam int BW = 42;
    localparam int PW = 52;
    localparam int LW = 66;
    localparam int NW = 64;
    localparam int NCH = 3;
    localparam int NKNOT = 22;

    typedef logic [KW-1:0] knot_t;
    typedef logic signed [CW-1:0] coef_t;

    localparam knot_t KNOT_R [NKNOT] = '{
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd59438, 17'd54280, 17'd50187, 17'd46875, 17'd44150,
        17'd41877, 17'd39956, 17'd39956, 17'd39956};
    localparam knot_t KNOT_G [NKNOT] = '{
        17'd1802,  17'd1802,  17'd9808,  17'd16819, 17'd24382, 17'd31243,
        17'd37380, 17'd42826, 17'd47637, 17'd51875, 17'd55605, 17'd58889,
        17'd61785, 17'd58357, 17'd55171, 17'd52553, 17'd50370, 17'd48524,
        17'd46947, 17'd45586, 17'd45586, 17'd45586};
    localparam knot_t KNOT_B [NKNOT] = '{
        17'd0,     17'd0,     17'd0,     17'd531,   17'd4420,  17'd10066,
        17'd16987, 17'd24717, 17'd32873, 17'd41160, 17'd49364, 17'd57338,
        17'd64988, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536};

    function automatic knot_t knot(input logic [IW-1:0] idx, input logic [1:0] ch);
        knot_t k;
        k = '0;
        case (ch)
            2'd0: k = KNOT_R[idx];
            2'd1: k = KNOT_G[idx];
            default: k = KNOT_B[idx];
        endcase
        return k;
    endfunction
endpackage
`default_nettype wire

@@ hdl/blackbody_temperature_to_rgb.sv @@
// blackbody temperature to rgb: catmull-rom spline pipeline with luminance normalize
// throughput: one transaction per cycle; the whole pipeline holds while a result waits
// with m_axis_tready low; output stage empty means s_axis_tready is high
// aresetn synchronous active low clears all valid bits; data registers are not reset
`default_nettype none
module blackbody_temperature_to_rgb #(
    parameter int OUT_FRAC_BITS = bbt_pkg::OUT_FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] kelvin
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // [15:0] red, [31:16] green, [47:32] blue
);
    localparam int NS = 26;
    localparam int WW = 81 + OUT_FRAC_BITS;
    localparam int NCH = bbt_pkg::NCH;
    localparam int QB = bbt_pkg::QBITS;

    logic adv;
    logic [NS-1:0] v_reg;

    assign adv = !v_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], s_axis_tvalid};
        end
    end

    // stage 1: clamp and segment select
    logic [bbt_pkg::TW-1:0] t_c;
    logic [bbt_pkg::DW-1:0] d_next, d1_reg;
    logic [27:0] seg_prod;
    logic [bbt_pkg::IW-1:0] seg1_reg;

    always_comb begin
        t_c = s_axis_tdata;
        if (s_axis_tdata < bbt_pkg::TW'(bbt_pkg::T_MIN)) t_c = bbt_pkg::TW'(bbt_pkg::T_MIN);
        if (s_axis_tdata > bbt_pkg::TW'(bbt_pkg::T_MAX)) t_c = bbt_pkg::TW'(bbt_pkg::T_MAX);
        d_next = bbt_pkg::DW'(t_c - bbt_pkg::TW'(bbt_pkg::T_MIN));
        seg_prod = 28'(d_next) * 28'(bbt_pkg::SEG_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg <= d_next;
            seg1_reg <= seg_prod[bbt_pkg::SEG_SHIFT +: bbt_pkg::IW];
        end
    end

    // stage 2: fraction and spline coefficients
    logic [bbt_pkg::DW-1:0] rfull;
    logic [bbt_pkg::RW-1:0] r2_reg, r3_reg, r4_reg;
    bbt_pkg::coef_t k0 [NCH], k1 [NCH], k2 [NCH], k3 [NCH];
    bbt_pkg::coef_t c0_next [NCH], c1_next [NCH], c2_next [NCH], c3_next [NCH];
    bbt_pkg::coef_t c0_reg [NCH], c1_reg [NCH], c2_reg [NCH], c3_reg [NCH];
    bbt_pkg::coef_t c2_3_reg [NCH], c3_3_reg [NCH], c3_4_reg [NCH];

    always_comb begin
        rfull = d1_reg - bbt_pkg::DW'(seg1_reg) * bbt_pkg::DW'(bbt_pkg::SEG_K);
        for (int c = 0; c < NCH; c++) begin
            k0[c] = $signed({6'b0, bbt_pkg::knot(seg1_reg, 2'(c))});
            k1[c] = $signed({6'b0, bbt_pkg::knot(seg1_reg + 5'd1, 2'(c))});
            k2[c] = $signed({6'b0, bbt_pkg::knot(seg1_reg + 5'd2, 2'(c))});
            k3[c] = $signed({6'b0, bbt_pkg::knot(seg1_reg + 5'd3, 2'(c))});
            c0_next[c] = k1[c] + k1[c] + k1[c] - k2[c] - k2[c] - k2[c] + k3[c] - k0[c];
            c1_next[c] = (k0[c] <<< 1) - (k1[c] <<< 2) - k1[c] + (k2[c] <<< 2) - k3[c];
            c2_next[c] = k2[c] - k0[c];
            c3_next[c] = k1[c] <<< 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r2_reg <= rfull[bbt_pkg::RW-1:0];
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
        end
    end

    // stages 3 to 5: horner evaluation, one horner step per stage
    logic signed [bbt_pkg::AW-1:0] a_next [NCH], a_reg [NCH];
    logic signed [bbt_pkg::BW-1:0] b_next [NCH], b_reg [NCH];
    logic signed [bbt_pkg::PW-1:0] p_next [NCH], p_reg [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            a_next[c] = bbt_pkg::AW'(c0_reg[c]) * $signed(bbt_pkg::AW'({1'b0, r2_reg}))
                      + bbt_pkg::AW'(c1_reg[c]) * bbt_pkg::AW'(bbt_pkg::SEG_K);
            b_next[c] = bbt_pkg::BW'(a_reg[c]) * $signed(bbt_pkg::BW'({1'b0, r3_reg}))
                      + bbt_pkg::BW'(c2_3_reg[c]) * bbt_pkg::BW'(bbt_pkg::SEG_SQ);
            p_next[c] = bbt_pkg::PW'(b_reg[c]) * $signed(bbt_pkg::PW'({1'b0, r4_reg}))
                      + bbt_pkg::PW'(c3_4_reg[c]) * bbt_pkg::PW'(bbt_pkg::SEG_CU);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= a_next;
            r3_reg <= r2_reg;
            c2_3_reg <= c2_reg;
            c3_3_reg <= c3_reg;
            b_reg <= b_next;
            r4_reg <= r3_reg;
            c3_4_reg <= c3_3_reg;
            p_reg <= p_next;
        end
    end

    // stage 6: luminance and scaled numerators
    logic signed [bbt_pkg::LW-1:0] lsum_next, lsum_reg;
    logic signed [bbt_pkg::LW-1:0] nt [NCH];
    logic [bbt_pkg::NW-1:0] num_next [NCH], num_reg [NCH];

    always_comb begin
        lsum_next = bbt_pkg::LW'(p_reg[0]) * bbt_pkg::LW'(bbt_pkg::W_R)
                  + bbt_pkg::LW'(p_reg[1]) * bbt_pkg::LW'(bbt_pkg::W_G)
                  + bbt_pkg::LW'(p_reg[2]) * bbt_pkg::LW'(bbt_pkg::W_B);
        for (int c = 0; c < NCH; c++) begin
            nt[c] = bbt_pkg::LW'(p_reg[c]) * bbt_pkg::LW'(bbt_pkg::LUM_SCALE);
            num_next[c] = (p_reg[c] > 0) ? nt[c][bbt_pkg::NW-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lsum_reg <= lsum_next;
            num_reg <= num_next;
        end
    end

    // stage 7: divider setup and saturation check; then one quotient bit per stage
    logic [WW-1:0] rem_reg [QB+1][NCH];
    logic [WW-1:0] rem_next [QB+1][NCH];
    logic [QB-1:0] q_reg [QB+1][NCH];
    logic [QB-1:0] q_next [QB+1][NCH];
    logic [NCH-1:0] sat_reg [QB+1];
    logic [NCH-1:0] sat_next [QB+1];
    logic [WW-1:0] den_reg [QB+1];
    logic [WW-1:0] den_next [QB+1];
    logic [QB:0] zero_reg;
    logic [QB:0] zero_next;
    logic [WW-1:0] dsh;

    always_comb begin
        den_next[0] = WW'(lsum_reg[bbt_pkg::NW-1:0]);
        zero_next[0] = !(lsum_reg > 0);
        for (int c = 0; c < NCH; c++) begin
            rem_next[0][c] = WW'(num_reg[c]) << (OUT_FRAC_BITS + 1);
            q_next[0][c] = '0;
            sat_next[0][c] = rem_next[0][c] >= (den_next[0] << QB);
        end
        for (int i = 1; i <= QB; i++) begin
            den_next[i] = den_reg[i-1];
            zero_next[i] = zero_reg[i-1];
            sat_next[i] = sat_reg[i-1];
            dsh = den_reg[i-1] << (QB - i);
            for (int c = 0; c < NCH; c++) begin
                if (rem_reg[i-1][c] >= dsh) begin
                    rem_next[i][c] = rem_reg[i-1][c] - dsh;
                    q_next[i][c] = {q_reg[i-1][c][QB-2:0], 1'b1};
                end else begin
                    rem_next[i][c] = rem_reg[i-1][c];
                    q_next[i][c] = {q_reg[i-1][c][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            sat_reg <= sat_next;
            den_reg <= den_next;
            zero_reg <= zero_next;
        end
    end

    // final stage: round and saturate; zero output when the luminance is not positive
    logic [QB:0] rnd [NCH];
    logic [47:0] out_next, out_reg;

    always_comb begin
        out_next = '0;
        for (int c = 0; c < NCH; c++) begin
            rnd[c] = ({1'b0, q_reg[QB][c]} + (QB+1)'(1)) >> 1;
            if (zero_reg[QB]) out_next[c*16 +: 16] = '0;
            else if (sat_reg[QB][c] || (rnd[c] > (QB+1)'(16'hFFFF)))
                out_next[c*16 +: 16] = 16'hFFFF;
            else out_next[c*16 +: 16] = rnd[c][15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tdata = out_reg;
endmodule
`default_nettype wire

@@ hdl/bbt_checker.sv @@
// port checker for the temperature to rgb pipeline and its bind
`default_nettype none
`include "assert_macros.svh"
module bbt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    // stalled result keeps its data
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result data changed while stalled")
    // no result right after reset
    `ASSERT_NEXT_ALL(a_rst, aclk, !aresetn, !m_axis_tvalid, "result valid after reset")
    // empty output stage never blocks the input
    `ASSERT_SAME(a_rdy, aclk, aresetn, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
    // a draining output frees the input
    `ASSERT_SAME(a_drain, aclk, aresetn, m_axis_tready, s_axis_tready, "input stalled while output drains")
    // accepted input transaction carries known data
    `ASSERT_SAME(a_known, aclk, aresetn, s_axis_tvalid && s_axis_tready, !$isunknown(s_axis_tdata), "unknown input data accepted")
endmodule

bind blackbody_temperature_to_rgb bbt_checker u_bbt_checker (.*);
`default_nettype wire

@@ tb/blackbody_temperature_to_rgb_checker.sv @@
// checker: predicts rgb for each accepted temperature and compares the result transactions
`default_nettype none
module blackbody_temperature_to_rgb_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);
    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgb_t;

    localparam int FRAC = bbt_pkg::OUT_FRAC_BITS;
    localparam longint SAT = 64'hFFFF;

    rgb_t expected_rgb [$];

    function automatic longint knot_value(int idx, int ch);
        case (ch)
            0: return longint'(bbt_pkg::KNOT_R[idx]);
            1: return longint'(bbt_pkg::KNOT_G[idx]);
            default: return longint'(bbt_pkg::KNOT_B[idx]);
        endcase
    endfunction

    // rounded, saturated num * 2^FRAC / den
    function automatic logic [15:0] normalize(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = num / den;
        rem = num % den;
        if (q > SAT) return 16'hFFFF;
        for (int i = 0; i < FRAC + 1; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q | 1;
            end
            if (q > (SAT << 1) + 1) return 16'hFFFF;
        end
        q = (q + 1) >> 1;
        return (q > SAT) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic rgb_t spline_rgb(logic [15:0] kelvin);
        longint t;
        longint seg;
        longint frac;
        longint p [3];
        longint lsum;
        longint k0, k1, k2, k3, c0, c1, c2, c3;
        logic [15:0] ch_out [3];
        rgb_t res;
        t = kelvin;
        if (t < bbt_pkg::T_MIN) t = bbt_pkg::T_MIN;
        if (t > bbt_pkg::T_MAX) t = bbt_pkg::T_MAX;
        seg = (t - bbt_pkg::T_MIN) / bbt_pkg::SEG_K;
        frac = (t - bbt_pkg::T_MIN) % bbt_pkg::SEG_K;
        if (seg > bbt_pkg::NKNOT - 4) seg = bbt_pkg::NKNOT - 4;
        lsum = 0;
        for (int c = 0; c < 3; c++) begin
            k0 = knot_value(int'(seg), c);
            k1 = knot_value(int'(seg + 1), c);
            k2 = knot_value(int'(seg + 2), c);
            k3 = knot_value(int'(seg + 3), c);
            c0 = -k0 + 3 * k1 - 3 * k2 + k3;
            c1 = 2 * k0 - 5 * k1 + 4 * k2 - k3;
            c2 = k2 - k0;
            c3 = 2 * k1;
            p[c] = ((c0 * frac + c1 * 500) * frac + c2 * 64'sd250000) * frac
                   + c3 * 64'sd125000000;
        end
        lsum = 2126 * p[0] + 7152 * p[1] + 722 * p[2];
        for (int c = 0; c < 3; c++) begin
            ch_out[c] = '0;
            if (lsum > 0 && p[c] > 0)
                ch_out[c] = normalize(longint'(p[c] * 10000), longint'(lsum));
        end
        res.red = ch_out[0];
        res.green = ch_out[1];
        res.blue = ch_out[2];
        return res;
    endfunction

    always @(posedge aclk) begin
        rgb_t got;
        rgb_t want;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
            pending_count <= 0;
            expected_rgb.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_rgb.insert(expected_rgb.size(), spline_rgb(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                result_count <= result_count + 1;
                if (expected_rgb.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_rgb.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_rgb.size();
        end
    end
endmodule
`default_nettype wire

@@ tb/blackbody_temperature_to_rgb_tb.sv @@
// testbench top: temperature stimulus, idle phases, backpressure and verdict
`default_nettype none
module blackbody_temperature_to_rgb_tb;
    localparam int LATENCY = 26;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          result_count;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int hold_cycles = 0;
    int idle_cycles = 0;
    int sent_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    blackbody_temperature_to_rgb i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    blackbody_temperature_to_rgb_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // receiver: random stalls, or a long hold-off counted here
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (hold_off) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= 300;
            hold_off <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("blackbody_temperature_to_rgb test failed");
            $finish;
        end
    end

    task automatic send_temperature(logic [15:0] kelvin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= kelvin;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_temperature();
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(1000));
            2: return 16'(1000 + 500 * $urandom_range(18) + $urandom_range(1) * 499);
            3: return 16'(10000 + $urandom_range(3));
            default: return 16'($urandom_range(10000, 1000));
        endcase
    endfunction

    initial begin
        logic [15:0] directed [];
        int phase_pct [4][2];
        directed = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001,
            16'd1499, 16'd1500, 16'd2000, 16'd3250, 16'd6499, 16'd6500, 16'd6501,
            16'd7000, 16'd9499, 16'd9500, 16'd9999, 16'd10000, 16'd10001,
            16'd32768, 16'd65535, 16'h5555, 16'hAAAA};
        phase_pct = '{'{0, 0}, '{64, 0}, '{0, 64}, '{6, 6}};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_temperature(directed[i]);
        wait_drained();
        // fill the pipeline against a long hold-off
        hold_off <= 1'b1;
        for (int i = 0; i < 60; i++) send_temperature(random_temperature());
        wait_drained();
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = phase_pct[ph % 4][0];
            recv_stall_pct = phase_pct[ph % 4][1];
            for (int i = 0; i < 200; i++) send_temperature(random_temperature());
            if (ph == 3) wait_drained();
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("covered %0d temperatures (clamps, knot edges, random) and %0d results",
                 sent_count, result_count);
        $display("idle phases: none, sender 64%%, receiver 64%%, both 6%%, plus long hold-off");
        if (fail_count == 0 && pending_count == 0)
            $display("blackbody_temperature_to_rgb test passed");
        else
            $display("blackbody_temperature_to_rgb test failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/bbt_pkg.sv
hdl/blackbody_temperature_to_rgb.sv
hdl/bbt_checker.sv
tb/blackbody_temperature_to_rgb_checker.sv
tb/blackbody_temperature_to_rgb_tb.sv
